### hdl/bitmap_frame_allocator_core_defines.svh
// assertion macros for the frame allocator core
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// condition holds at every edge outside reset
`define BFA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the trigger
`define BFA_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### hdl/bfa_pkg.sv
// shared constants for the frame allocator core
package bfa_pkg;

   localparam int ADDR_W     = 32;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 19;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MEM_LOW   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_LIMIT = 1'd1;

endpackage

### hdl/bfa_map_ram.sv
// used-bit map storage: one write port, one read port, registered read data
module bfa_map_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 8192,
   parameter int ADDR_W = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/bfa_first_zero.sv
// finds the lowest clear bit of a map word outside the masked positions
module bfa_first_zero #(
   parameter int WORD_BITS = 32,
   parameter int IDX_W     = 5
) (
   input  logic [WORD_BITS-1:0] word,
   input  logic [WORD_BITS-1:0] lo_mask,
   input  logic [WORD_BITS-1:0] hi_mask,
   output logic                 found,
   output logic [IDX_W-1:0]     index
);

   logic [WORD_BITS-1:0] avail;

   assign avail = ~(word | lo_mask | hi_mask);
   assign found = |avail;

   always_comb begin
      index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            index = IDX_W'(i);
         end
      end
   end

endmodule

### hdl/bitmap_frame_allocator_core.sv
// Bitmap physical frame allocator: one used bit per frame, kept in a single-port-read,
// single-port-write map RAM of MAP_FRAMES/MAP_WORD_BITS words. After reset the map is
// wiped word by word with req_tready low. One request is handled at a time. Allocate
// reads and checks the map words in turn, from the word of the first managed frame to the
// first word with a free bit or the last word of the window, then responds; free reads the
// frame's word, checks its bit and clears it if set, then responds; initialize rewrites
// every map word and then responds. The map RAM read-then-check loop sets the allocate
// time. mem_low and mem_limit take effect at the next initialize.
module bitmap_frame_allocator_core #(
   parameter int FRAME_BYTES   = 4096,
   parameter int MAP_FRAMES    = 262144,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bfa_pkg::REQ_DATA_W-1:0]    req_tdata,  // op, free_addr
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tdata: status, alloc_addr, free_count, total_count
   input  logic                              csr_we,
   input  logic [bfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfa_pkg::ADDR_W-1:0]        csr_wdata
);

`include "bitmap_frame_allocator_core_defines.svh"

   localparam int FBL        = $clog2(FRAME_BYTES);
   localparam int WBL        = $clog2(MAP_WORD_BITS);
   localparam int MAP_WORDS  = (MAP_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W      = $clog2(MAP_FRAMES + 1);
   localparam int WNUM_W     = CNT_W - WBL;
   localparam int BASE_W     = bfa_pkg::ADDR_W + 1 - FBL;
   localparam int TOP_W      = bfa_pkg::ADDR_W - FBL;
   localparam int CMP_W      = ((BASE_W > CNT_W) ? BASE_W : CNT_W) + 1;

   typedef enum logic [3:0] {
      S_WIPE, S_IDLE, S_SIZE, S_CLEAR, S_ARD, S_ACHK, S_FRD, S_FCHK, S_PUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [bfa_pkg::ADDR_W-1:0]      mem_low_ff, mem_low_in;
   logic [bfa_pkg::ADDR_W-1:0]      mem_limit_ff, mem_limit_in;
   logic [BASE_W-1:0]               base_ff, base_in;
   logic [TOP_W-1:0]                top_ff, top_in;
   logic [CNT_W-1:0]                end_ff, end_in;
   logic [CNT_W-1:0]                managed_ff, managed_in;
   logic [CNT_W-1:0]                free_ff, free_in;
   logic [WORD_IDX_W-1:0]           clr_ff, clr_in;
   logic [WNUM_W-1:0]               cur_ff, cur_in;
   logic [WBL-1:0]                  fbit_ff, fbit_in;
   logic [bfa_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [bfa_pkg::ADDR_W-1:0]      res_addr_ff, res_addr_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [bfa_pkg::RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                            ram_we;
   logic [WORD_IDX_W-1:0]           ram_wr_addr;
   logic [MAP_WORD_BITS-1:0]        ram_wr_data;
   logic [MAP_WORD_BITS-1:0]        ram_q;

   logic [MAP_WORD_BITS-1:0]        lo_mask;
   logic [MAP_WORD_BITS-1:0]        hi_mask;
   logic                            zero_found;
   logic [WBL-1:0]                  zero_idx;

   logic [bfa_pkg::OP_W-1:0]        req_op;
   logic [bfa_pkg::ADDR_W-1:0]      req_addr;
   logic [TOP_W-1:0]                req_frame;
   logic                            req_xfer;
   logic                            slot_free;
   logic [bfa_pkg::ADDR_W:0]        low_round;
   logic [WNUM_W-1:0]               base_word;
   logic [WNUM_W-1:0]               end_word;
   logic [WNUM_W-1:0]               last_word;
   logic [CMP_W-1:0]                win_sum;
   logic [CMP_W-1:0]                size_diff;
   logic [CNT_W-1:0]                found_frame;
   logic [63:0]                     found_addr;
   logic [31:0]                     free_wide;
   logic [31:0]                     total_wide;

   assign req_op    = req_tdata[1:0];
   assign req_addr  = req_tdata[33:2];
   assign req_frame = TOP_W'(req_addr >> FBL);
   assign req_xfer  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   assign low_round = {1'b0, mem_low_ff} + (bfa_pkg::ADDR_W + 1)'(FRAME_BYTES - 1);
   assign base_word = WNUM_W'(base_ff >> WBL);
   assign end_word  = WNUM_W'(end_ff >> WBL);
   assign last_word = WNUM_W'((end_ff - CNT_W'(1)) >> WBL);
   assign win_sum   = CMP_W'(base_ff) + CMP_W'(managed_ff);
   assign size_diff = CMP_W'(top_ff) - CMP_W'(base_ff);

   assign lo_mask = (cur_ff == base_word) ?
                    ~({MAP_WORD_BITS{1'b1}} << base_ff[WBL-1:0]) : '0;
   assign hi_mask = (cur_ff == end_word) ?
                    ({MAP_WORD_BITS{1'b1}} << end_ff[WBL-1:0]) : '0;

   assign found_frame = {cur_ff, zero_idx};
   assign found_addr  = 64'(found_frame) << FBL;
   assign free_wide   = 32'(free_ff);
   assign total_wide  = 32'(managed_ff);

   bfa_map_ram #(
      .WIDTH  (MAP_WORD_BITS),
      .DEPTH  (MAP_WORDS),
      .ADDR_W (WORD_IDX_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cur_ff[WORD_IDX_W-1:0]),
      .rd_data (ram_q)
   );

   bfa_first_zero #(
      .WORD_BITS (MAP_WORD_BITS),
      .IDX_W     (WBL)
   ) u_first_zero (
      .word    (ram_q),
      .lo_mask (lo_mask),
      .hi_mask (hi_mask),
      .found   (zero_found),
      .index   (zero_idx)
   );

   always_comb begin
      state_in      = state_ff;
      mem_low_in    = mem_low_ff;
      mem_limit_in  = mem_limit_ff;
      base_in       = base_ff;
      top_in        = top_ff;
      end_in        = end_ff;
      managed_in    = managed_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      fbit_in       = fbit_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = cur_ff[WORD_IDX_W-1:0];
      ram_wr_data   = '0;

      if (csr_we) begin
         case (csr_index)
            bfa_pkg::CSR_MEM_LOW:   mem_low_in   = csr_wdata;
            bfa_pkg::CSR_MEM_LIMIT: mem_limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_WIPE, S_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            end_in = (win_sum > CMP_W'(MAP_FRAMES)) ? CNT_W'(MAP_FRAMES)
                                                    : win_sum[CNT_W-1:0];
            if (clr_ff == WORD_IDX_W'(MAP_WORDS - 1)) begin
               state_in = (state_ff == S_WIPE) ? S_IDLE : S_PUT;
            end else begin
               clr_in = clr_ff + WORD_IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               res_status_in = bfa_pkg::ST_OK;
               res_addr_in   = '0;
               case (req_op)
                  bfa_pkg::OP_ALLOC: begin
                     if (free_ff == '0 || CMP_W'(base_ff) >= CMP_W'(end_ff)) begin
                        res_status_in = bfa_pkg::ST_NO_FREE;
                        state_in      = S_PUT;
                     end else begin
                        cur_in   = base_word;
                        state_in = S_ARD;
                     end
                  end
                  bfa_pkg::OP_FREE: begin
                     if (CMP_W'(req_frame) < CMP_W'(base_ff) ||
                         CMP_W'(req_frame) >= CMP_W'(end_ff)) begin
                        res_status_in = bfa_pkg::ST_OUT_RANGE;
                        state_in      = S_PUT;
                     end else begin
                        cur_in   = WNUM_W'(req_frame >> WBL);
                        fbit_in  = req_frame[WBL-1:0];
                        state_in = S_FRD;
                     end
                  end
                  bfa_pkg::OP_INIT: begin
                     base_in  = BASE_W'(low_round >> FBL);
                     top_in   = TOP_W'(mem_limit_ff >> FBL);
                     state_in = S_SIZE;
                  end
                  default: state_in = S_PUT;
               endcase
            end
         end
         S_SIZE: begin
            if (CMP_W'(top_ff) > CMP_W'(base_ff)) begin
               managed_in = (size_diff > CMP_W'(MAP_FRAMES)) ? CNT_W'(MAP_FRAMES)
                                                             : size_diff[CNT_W-1:0];
            end else begin
               managed_in = '0;
            end
            free_in  = managed_in;
            clr_in   = '0;
            state_in = S_CLEAR;
         end
         S_ARD: state_in = S_ACHK;
         S_ACHK: begin
            if (zero_found) begin
               ram_we      = 1'b1;
               ram_wr_data = ram_q | (MAP_WORD_BITS'(1) << zero_idx);
               free_in     = free_ff - CNT_W'(1);
               res_addr_in = found_addr[31:0];
               state_in    = S_PUT;
            end else if (cur_ff == last_word) begin
               res_status_in = bfa_pkg::ST_NO_FREE;
               state_in      = S_PUT;
            end else begin
               cur_in   = cur_ff + WNUM_W'(1);
               state_in = S_ARD;
            end
         end
         S_FRD: state_in = S_FCHK;
         S_FCHK: begin
            if (!ram_q[fbit_ff]) begin
               res_status_in = bfa_pkg::ST_NOT_ALLOC;
            end else begin
               ram_we      = 1'b1;
               ram_wr_data = ram_q & ~(MAP_WORD_BITS'(1) << fbit_ff);
               free_in     = free_ff + CNT_W'(1);
            end
            state_in = S_PUT;
         end
         S_PUT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {total_wide[bfa_pkg::COUNT_W-1:0],
                                free_wide[bfa_pkg::COUNT_W-1:0],
                                res_addr_ff, res_status_ff};
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WIPE;
         mem_low_ff    <= '0;
         mem_limit_ff  <= '0;
         base_ff       <= '0;
         top_ff        <= '0;
         end_ff        <= '0;
         managed_ff    <= '0;
         free_ff       <= '0;
         clr_ff        <= '0;
         cur_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mem_low_ff    <= mem_low_in;
         mem_limit_ff  <= mem_limit_in;
         base_ff       <= base_in;
         top_ff        <= top_in;
         end_ff        <= end_in;
         managed_ff    <= managed_in;
         free_ff       <= free_in;
         clr_ff        <= clr_in;
         cur_ff        <= cur_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      fbit_ff       <= fbit_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // free frames never exceed the managed window
   `BFA_ASSERT_ALWAYS(a_free_le_total, clock, reset, free_ff <= managed_ff, "free count above total")
   // managed window never runs past the map
   `BFA_ASSERT_ALWAYS(a_end_in_map, clock, reset, end_ff <= CNT_W'(MAP_FRAMES), "window end past map")
   // one request at a time
   `BFA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_xfer, !req_tready, "ready after transfer")

endmodule

### bench/bitmap_frame_allocator_core_tb.sv
// self-checking stream testbench for the bitmap frame allocator core
module bitmap_frame_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int FRAME_BYTES   = 4096;
   localparam int MAP_FRAMES    = 262144;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = MAP_FRAMES / MAP_WORD_BITS;
   localparam int RANDOM_ITEMS  = 650;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int OP_W          = bfa_pkg::OP_W;
   localparam int ADDR_W        = bfa_pkg::ADDR_W;
   localparam int COUNT_W       = bfa_pkg::COUNT_W;
   localparam int STATUS_W      = bfa_pkg::STATUS_W;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [MAP_WORD_BITS-1:0] map_word_type;

   typedef struct packed {
      logic [bfa_pkg::REQ_DATA_W-OP_W-ADDR_W-1:0] pad;
      logic [ADDR_W-1:0]                          free_addr;
      logic [OP_W-1:0]                            op;
   } alloc_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  total_count;
      logic [COUNT_W-1:0]  free_count;
      logic [ADDR_W-1:0]   alloc_addr;
      logic [STATUS_W-1:0] status;
   } alloc_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bfa_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // op, free_addr
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // status, alloc_addr, free_count, total_count
   logic [bfa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ADDR_W-1:0]              csr_wdata  = '0;

   // allocator mirror
   map_word_type    used_map [MAP_WORDS];
   longint unsigned base_frame     = 0;
   longint unsigned managed_frames = 0;
   longint unsigned free_left      = 0;
   logic [ADDR_W-1:0] cfg_mem_low   = '0;
   logic [ADDR_W-1:0] cfg_mem_limit = '0;

   alloc_req_type    stim_items [$];
   alloc_result_type expected_results [$];

   logic req_taken   = 1'b0;
   logic rsp_taken   = 1'b0;
   int   req_gap     = 0;
   int   req_quiet   = 0;
   int   rsp_wait    = 0;
   int   rsp_quiet   = 0;
   int   rsp_hold    = 0;
   logic hold_done   = 1'b0;
   int   rsp_seen    = 0;
   int   err_count   = 0;
   int   cycle_count = 0;

   bitmap_frame_allocator_core #(
      .FRAME_BYTES  (FRAME_BYTES),
      .MAP_FRAMES   (MAP_FRAMES),
      .MAP_WORD_BITS(MAP_WORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic alloc_result_type predict_alloc_result(input logic [OP_W-1:0] op,
                                                            input logic [ADDR_W-1:0] addr);
      alloc_result_type r;
      longint unsigned  lo64, hi64, first, top, span, f, stop;
      bit               found;
      r        = '0;
      r.status = bfa_pkg::ST_OK;
      stop     = base_frame + managed_frames;
      if (stop > MAP_FRAMES) stop = MAP_FRAMES;
      case (op)
         bfa_pkg::OP_INIT: begin
            lo64  = cfg_mem_low;
            hi64  = cfg_mem_limit;
            first = (lo64 + FRAME_BYTES - 1) / FRAME_BYTES;
            top   = hi64 / FRAME_BYTES;
            span  = (top > first) ? top - first : 0;
            if (span > MAP_FRAMES) span = MAP_FRAMES;
            // frames below the window are marked used
            for (int w = 0; w < MAP_WORDS; w++) begin
               if ((w + 1) * MAP_WORD_BITS <= first) begin
                  used_map[w] = '1;
               end else if (w * MAP_WORD_BITS < first) begin
                  used_map[w] = (map_word_type'(1) << (first - w * MAP_WORD_BITS))
                                - map_word_type'(1);
               end else begin
                  used_map[w] = '0;
               end
            end
            base_frame     = first;
            managed_frames = span;
            free_left      = span;
         end
         bfa_pkg::OP_ALLOC: begin
            found = 1'b0;
            f     = base_frame;
            if (free_left != 0) begin
               while (!found && f < stop) begin
                  if (!used_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS]) found = 1'b1;
                  else f++;
               end
            end
            if (found) begin
               used_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS] = 1'b1;
               free_left--;
               r.alloc_addr = ADDR_W'(f * FRAME_BYTES);
            end else begin
               r.status = bfa_pkg::ST_NO_FREE;
            end
         end
         bfa_pkg::OP_FREE: begin
            f = addr / FRAME_BYTES;
            if (f < base_frame || f >= stop) begin
               r.status = bfa_pkg::ST_OUT_RANGE;
            end else if (!used_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS]) begin
               r.status = bfa_pkg::ST_NOT_ALLOC;
            end else begin
               used_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS] = 1'b0;
               free_left++;
            end
         end
         default: ;
      endcase
      r.free_count  = COUNT_W'(free_left);
      r.total_count = COUNT_W'(managed_frames);
      return r;
   endfunction

   task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
      alloc_req_type item;
      item           = '0;
      item.op        = op;
      item.free_addr = addr;
      stim_items.push_back(item);
   endtask

   // sampled at the rising edge so a request launched at the falling edge is seen
   task automatic wait_idle();
      do @(posedge clock);
      while (stim_items.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic apply_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= bfa_pkg::CSR_MEM_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= bfa_pkg::CSR_MEM_LIMIT;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // request source
   always @(negedge clock) begin : req_source
      int w;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (stim_items.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= stim_items.pop_front();
            if (req_quiet > 0) begin
               req_quiet <= req_quiet - 1;
               req_gap   <= 0;
            end else if ($urandom_range(0, 15) == 0) begin
               req_quiet <= $urandom_range(10, 30);
               req_gap   <= 0;
            end else begin
               w       = $urandom_range(0, 6);
               req_gap <= w;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver stall once traffic is flowing
   always @(negedge clock) begin : rsp_holdoff
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!hold_done && rsp_seen >= 100 && stim_items.size() > 4) begin
         rsp_hold  <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // response sink
   always @(negedge clock) begin : rsp_sink
      int w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         if (rsp_quiet > 0) begin
            rsp_quiet  <= rsp_quiet - 1;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_quiet  <= $urandom_range(10, 30);
            rsp_tready <= 1'b1;
         end else begin
            w          = $urandom_range(0, 6);
            rsp_wait   <= w;
            rsp_tready <= (w == 0);
         end
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         if (rsp_tvalid) rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin : monitor
      alloc_result_type got, want;
      alloc_req_type    item;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got      = rsp_tdata;
            rsp_seen <= rsp_seen + 1;
            if (expected_results.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected result at cycle %0d: status %0d addr %h free %0d total %0d",
                           cycle_count, got.status, got.alloc_addr, got.free_count,
                           got.total_count);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.alloc_addr !== want.alloc_addr ||
                   got.free_count !== want.free_count || got.total_count !== want.total_count)
               begin
                  err_count++;
                  if (err_count <= 10)
                     $display(
                        "mismatch cycle %0d exp/act: st %0d/%0d addr %h/%h free %0d/%0d tot %0d/%0d",
                        cycle_count, want.status, got.status, want.alloc_addr,
                        got.alloc_addr, want.free_count, got.free_count,
                        want.total_count, got.total_count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            item = req_tdata;
            expected_results.push_back(predict_alloc_result(item.op, item.free_addr));
         end
         if (csr_we) begin
            if (csr_index == bfa_pkg::CSR_MEM_LOW) cfg_mem_low = csr_wdata;
            else if (csr_index == bfa_pkg::CSR_MEM_LIMIT) cfg_mem_limit = csr_wdata;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] lo, hi;
      longint unsigned   lo64, gbase, gtop, gtotal, fr;
      int                sent, n, r;
      sent = 0;
      for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;

      // nothing managed before the first initialize
      push_item(bfa_pkg::OP_ALLOC, 32'h0000_0000);
      push_item(bfa_pkg::OP_FREE, 32'h0000_0000);
      push_item(OP_UNUSED, 32'hFFFF_FFFF);
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // five frames from frame zero, then exhaustion and bad frees
      apply_window(32'h0000_0000, 32'h0000_5000);
      push_item(bfa_pkg::OP_INIT, 32'h0000_0000);
      repeat (6) push_item(bfa_pkg::OP_ALLOC, $urandom);
      push_item(bfa_pkg::OP_FREE, 32'h0000_0000);
      push_item(bfa_pkg::OP_FREE, 32'h0000_0FFF);
      push_item(bfa_pkg::OP_FREE, 32'h0000_5000);
      push_item(bfa_pkg::OP_FREE, 32'hFFFF_FFFF);

      // window running past the map end
      apply_window(32'h3FFF_B001, 32'hFFFF_FFFF);
      push_item(bfa_pkg::OP_INIT, 32'h0000_0000);
      repeat (5) push_item(bfa_pkg::OP_ALLOC, $urandom);
      push_item(bfa_pkg::OP_FREE, 32'h3FFF_B000);
      push_item(bfa_pkg::OP_FREE, 32'h3FFF_F000);

      // empty window
      apply_window(32'hFFFF_FFFF, 32'h0000_0000);
      push_item(bfa_pkg::OP_INIT, 32'h0000_0000);
      push_item(bfa_pkg::OP_ALLOC, $urandom);
      push_item(bfa_pkg::OP_FREE, 32'hFFFF_F000);

      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               lo = $urandom_range(0, 32'h3FFF_FFFF);
               hi = lo + $urandom_range(0, 40) * FRAME_BYTES
                    + $urandom_range(0, FRAME_BYTES - 1);
            end
            2: begin
               lo = $urandom_range(0, 32'h3FFF_FFFF);
               hi = $urandom;
            end
            3: begin
               lo = $urandom;
               hi = $urandom;
            end
            4: begin
               lo = (MAP_FRAMES - $urandom_range(1, 40)) * FRAME_BYTES
                    - $urandom_range(0, FRAME_BYTES - 1);
               if ($urandom_range(0, 1) == 0) hi = '1;
               else hi = lo + $urandom_range(0, 60) * FRAME_BYTES;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: begin lo = '0; hi = '0; end
                  1: begin lo = '1; hi = '1; end
                  2: begin lo = '0; hi = '1; end
                  default: begin lo = '1; hi = '0; end
               endcase
            end
         endcase
         apply_window(lo, hi);
         lo64   = lo;
         gbase  = (lo64 + FRAME_BYTES - 1) / FRAME_BYTES;
         gtop   = hi / FRAME_BYTES;
         gtotal = (gtop > gbase) ? gtop - gbase : 0;
         if (gtotal > MAP_FRAMES) gtotal = MAP_FRAMES;
         n = $urandom_range(30, 70);
         push_item(bfa_pkg::OP_INIT, $urandom);
         for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               push_item(bfa_pkg::OP_ALLOC, $urandom);
            end else if (r < 92) begin
               if (r < 80) begin
                  fr = gbase + $urandom_range(0, (gtotal < 48) ? gtotal : 48);
               end else if (r < 85) begin
                  case ($urandom_range(0, 4))
                     0: fr = gbase - 1;
                     1: fr = gbase + gtotal;
                     2: fr = gbase + gtotal - 1;
                     3: fr = MAP_FRAMES - 1;
                     default: fr = MAP_FRAMES;
                  endcase
               end else begin
                  fr = $urandom_range(0, 32'h000F_FFFF);
               end
               push_item(bfa_pkg::OP_FREE, ADDR_W'(fr * FRAME_BYTES)
                                           | ADDR_W'($urandom_range(0, FRAME_BYTES - 1)));
            end else if (r < 97) begin
               push_item(OP_UNUSED, $urandom);
            end else begin
               push_item(bfa_pkg::OP_INIT, $urandom);
            end
         end
         sent += n;
      end

      wait_idle();
      repeat (50) @(negedge clock);
      err_count += expected_results.size();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
